### hdl/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg: hop channel select shared definitions
// Widths, register codes, request/result payload types and the map rank
// bundle passed between the map ranking unit and the top level.
// ----------------------------------------------------------------------------
package hcs_pkg;

  // field widths
  localparam int EC_W   = 16;   // event counter, also the prn width
  localparam int AA_W   = 32;   // access address
  localparam int MAP_W  = 37;   // channel map register
  localparam int CH_W   = 6;    // channel index
  localparam int CFG_W  = 37;   // widest configuration register
  localparam int IDX_W  = 1;    // configuration register index

  // channel map reset value: every channel used
  localparam logic [MAP_W-1:0] MAP_RESET = '1;

  // prn round multiplier
  localparam int PRN_MUL = 17;

  // map ranking: blocks of eight map bits
  localparam int BLOCK_W    = 8;
  localparam int MAP_BLOCKS = (MAP_W + BLOCK_W - 1) / BLOCK_W;
  localparam int RANK_W     = $clog2(MAP_W + 1);

  // datapath register stages from request to result
  localparam int PIPE_DEPTH = 6;

  // configuration register codes
  typedef enum logic [IDX_W-1:0] {
    REG_ACCESS_ADDRESS = 1'b0,
    REG_CHANNEL_MAP    = 1'b1
  } cfg_reg_t;

  // request payload
  typedef struct packed {
    logic [EC_W-1:0] event_counter;
  } req_t;

  // result payload
  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            remapped;
    logic            map_error;
  } res_t;

  // used-channel bits with their rank among used channels and the total
  typedef struct packed {
    logic [MAP_W-1:0]             used;
    logic [MAP_W-1:0][RANK_W-1:0] prefix;
    logic [RANK_W-1:0]            count;
  } map_rank_t;

endpackage

### hdl/hcs_stream_if.sv
// ----------------------------------------------------------------------------
// hcs_stream_if: valid/ready stream channel
// Carries one payload per request; a request moves when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface hcs_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### hdl/hop_channel_select_top.sv
// ----------------------------------------------------------------------------
// hop_channel_select_top: hop channel selection
// Maps a connection event counter to a data channel using the link access
// address and the used-channel map.
// ----------------------------------------------------------------------------
// Usage
//   req : one request per hop, payload event_counter.
//   res : one result per request, in request order: channel, remapped
//         (unmapped channel was unused and a used channel was picked by
//         rank) and map_error (map holds no used channel; channel is then
//         the unmapped channel).
//   cfg : cfg_we/cfg_index/cfg_data write access_address (index 0) or
//         channel_map (index 1); write only while no request is in flight.
// Timing
//   Six register stages: three prn rounds, reciprocal multiply, remainder
//   correction, rank lookup into the result register. One request is
//   taken every cycle until a stalled res has filled every stage. The
//   channel map rank is rebuilt through both register levels of
//   hcs_map_rank after a map write, ahead of any request that follows it.
// Reset
//   rst empties the pipeline, clears access_address and marks all
//   channels used.
// Backpressure
//   While res is stalled, stages keep filling until every stage holds a
//   request; req.ready drops only then. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module hop_channel_select_top #(
  parameter int NUM_CHANNELS = 37
) (
  input  logic                      clk,
  input  logic                      rst,
  hcs_stream_if.sink                req,
  hcs_stream_if.source              res,
  input  logic                      cfg_we,
  input  logic [hcs_pkg::IDX_W-1:0] cfg_index,
  input  logic [hcs_pkg::CFG_W-1:0] cfg_data
);

  localparam int EW = hcs_pkg::EC_W;
  localparam int RW = hcs_pkg::RANK_W;
  localparam int CW = hcs_pkg::CH_W;
  localparam int MW = hcs_pkg::MAP_W;
  localparam int ND = hcs_pkg::PIPE_DEPTH;
  localparam int NW = $clog2(NUM_CHANNELS + 1);
  localparam logic [NW-1:0] NCH   = NW'(NUM_CHANNELS);
  localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / NUM_CHANNELS);

  // configuration registers
  logic [hcs_pkg::AA_W-1:0] access_address;
  logic [MW-1:0]            channel_map;

  // pipeline control
  logic [ND-1:0] v;
  logic [ND-1:0] en;

  // datapath
  logic [EW-1:0]      ident;
  logic [EW-1:0]      r1_y, r2_y, r3_y;
  logic [EW-1:0]      s1_prn, s2_prn, s3_prn, s4_prn;
  logic [EW-1:0]      s4_q;
  logic [RW-1:0]      s4_target, s5_target;
  logic [CW-1:0]      s5_unmapped;
  logic [EW+31:0]     q_prod;
  logic [EW+RW-1:0]   t_prod;
  logic [EW+NW-1:0]   qn_prod;
  logic [EW-1:0]      rem_raw, rem;
  logic [CW-1:0]      sel;
  logic               unmapped_used;
  hcs_pkg::res_t      res_next;
  hcs_pkg::res_t      res_q;
  hcs_pkg::map_rank_t rank;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      access_address <= '0;
      channel_map    <= hcs_pkg::MAP_RESET;
    end else if (cfg_we) begin
      case (hcs_pkg::cfg_reg_t'(cfg_index))
        hcs_pkg::REG_ACCESS_ADDRESS: access_address <= cfg_data[hcs_pkg::AA_W-1:0];
        hcs_pkg::REG_CHANNEL_MAP:    channel_map    <= cfg_data[MW-1:0];
        default: ;
      endcase
    end
  end

  // channel identifier from the access address halves
  assign ident = access_address[31:16] ^ access_address[15:0];

  // map ranking unit
  hcs_map_rank #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_map_rank (
    .clk         (clk),
    .channel_map (channel_map),
    .rank        (rank)
  );

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[ND-1] = !v[ND-1] || res.ready;
    for (int k = ND - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign req.ready = en[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < ND; k++) begin
        if (en[k]) begin
          if (k == 0) begin
            v[k] <= req.valid;
          end else begin
            v[k] <= v[k-1];
          end
        end
      end
    end
  end

  // three prn rounds
  hcs_round u_round1 (.ident(ident), .x(req.payload.event_counter ^ ident), .y(r1_y));
  hcs_round u_round2 (.ident(ident), .x(s1_prn), .y(r2_y));
  hcs_round u_round3 (.ident(ident), .x(s2_prn), .y(r3_y));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_prn <= r1_y;
    end
    if (en[1]) begin
      s2_prn <= r2_y;
    end
    if (en[2]) begin
      s3_prn <= r3_y ^ ident;
    end
  end

  // quotient estimate by reciprocal and remap index
  assign q_prod = (EW + 32)'(s3_prn) * (EW + 32)'(RECIP);
  assign t_prod = (EW + RW)'(s3_prn) * (EW + RW)'(rank.count);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_prn    <= s3_prn;
      s4_q      <= q_prod[EW+31:32];
      s4_target <= t_prod[EW +: RW];
    end
  end

  // remainder with one correction step gives the unmapped channel
  always_comb begin
    qn_prod = (EW + NW)'(s4_q) * (EW + NW)'(NCH);
    rem_raw = s4_prn - qn_prod[EW-1:0];
    if (rem_raw >= EW'(NUM_CHANNELS)) begin
      rem = rem_raw - EW'(NUM_CHANNELS);
    end else begin
      rem = rem_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_unmapped <= rem[CW-1:0];
      s5_target   <= s4_target;
    end
  end

  // used-channel lookup and pick by rank
  always_comb begin
    sel = '0;
    for (int c = 0; c < MW; c++) begin
      if (rank.used[c] && (rank.prefix[c] == s5_target)) begin
        sel = sel | CW'(c);
      end
    end
    unmapped_used = (s5_unmapped < CW'(MW)) ? rank.used[s5_unmapped] : 1'b0;

    res_next.channel   = s5_unmapped;
    res_next.remapped  = 1'b0;
    res_next.map_error = 1'b0;
    if (rank.count == '0) begin
      res_next.map_error = 1'b1;
    end else if (!unmapped_used) begin
      res_next.channel  = sel;
      res_next.remapped = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en[5]) begin
      res_q <= res_next;
    end
  end

  assign res.valid   = v[ND-1];
  assign res.payload = res_q;

endmodule

### hdl/hcs_round.sv
// ----------------------------------------------------------------------------
// hcs_round: one prn round
// Reverses the bits within each byte, multiplies by 17 and adds the
// channel identifier, modulo 2^16.
// ----------------------------------------------------------------------------
module hcs_round (
  input  logic [hcs_pkg::EC_W-1:0] ident,
  input  logic [hcs_pkg::EC_W-1:0] x,
  output logic [hcs_pkg::EC_W-1:0] y
);

  logic [hcs_pkg::EC_W-1:0] perm;

  // bit reversal inside each byte
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      perm[i]     = x[7 - i];
      perm[8 + i] = x[15 - i];
    end
  end

  // multiply by constant and add identifier, wrap to 16 bits
  assign y = hcs_pkg::EC_W'(32'(perm) * 32'(hcs_pkg::PRN_MUL) + 32'(ident));

endmodule

### hdl/hcs_map_rank.sv
// ----------------------------------------------------------------------------
// hcs_map_rank: channel map ranking
// Two register levels: per-block popcounts and in-block partial counts,
// then the number of used channels below each channel and the total.
// ----------------------------------------------------------------------------
module hcs_map_rank #(
  parameter int NUM_CHANNELS = 37
) (
  input  logic                      clk,
  input  logic [hcs_pkg::MAP_W-1:0] channel_map,
  output hcs_pkg::map_rank_t        rank
);

  localparam int NB  = hcs_pkg::MAP_BLOCKS;
  localparam int BW  = hcs_pkg::BLOCK_W;
  localparam int RW  = hcs_pkg::RANK_W;
  localparam int MW  = hcs_pkg::MAP_W;
  localparam int PW  = $clog2(BW);       // in-block count width
  localparam int CW  = $clog2(BW + 1);   // block count width

  logic [NB*BW-1:0]         pad;
  logic [NB*BW-1:0][PW-1:0] part_next;
  logic [NB-1:0][CW-1:0]    blk_next;
  logic [MW-1:0]            used_a;
  logic [MW-1:0][PW-1:0]    part_a;
  logic [NB-1:0][CW-1:0]    blk_a;
  logic [NB:0][RW-1:0]      base;
  hcs_pkg::map_rank_t       rank_next;

  // drop map bits at or above the channel count, pad to whole blocks
  always_comb begin
    pad = '0;
    for (int c = 0; c < MW; c++) begin
      pad[c] = channel_map[c] && (c < NUM_CHANNELS);
    end
  end

  // used bits below each position within its block, and block totals
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      blk_next[b] = '0;
      for (int i = 0; i < BW; i++) begin
        part_next[b*BW + i] = blk_next[b][PW-1:0];
        blk_next[b]         = blk_next[b] + CW'(pad[b*BW + i]);
      end
    end
  end

  // first level
  always_ff @(posedge clk) begin
    used_a <= pad[MW-1:0];
    part_a <= part_next[MW-1:0];
    blk_a  <= blk_next;
  end

  // block bases and per-channel rank
  always_comb begin
    base[0] = '0;
    for (int b = 1; b <= NB; b++) begin
      base[b] = base[b-1] + RW'(blk_a[b-1]);
    end
    rank_next.used  = used_a;
    rank_next.count = base[NB];
    for (int c = 0; c < MW; c++) begin
      rank_next.prefix[c] = base[c / BW] + RW'(part_a[c]);
    end
  end

  // second level
  always_ff @(posedge clk) begin
    rank <= rank_next;
  end

endmodule

### hdl/hcs_checker.sv
// ----------------------------------------------------------------------------
// hcs_checker: port-level checks for hop_channel_select_top
// Watches the request and result channels; attached to the top level by
// the bind below.
// ----------------------------------------------------------------------------
module hcs_checker #(
  parameter int NUM_CHANNELS = 37
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_ready,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic [hcs_pkg::CH_W-1:0] channel,
  input logic                     remapped,
  input logic                     map_error
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable({channel, remapped, map_error}))
    else $error("result changed while stalled");

  // pipeline comes up empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // request side blocks only while the result is stalled
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> res_valid && !res_ready)
    else $error("request refused without a stalled result");

  // an empty map is never remapped
  a_error_no_remap: assert property (@(posedge clk) disable iff (rst)
    res_valid && map_error |-> !remapped)
    else $error("remapped set with map error");

  // channel stays within the channel count
  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (channel < NUM_CHANNELS))
    else $error("channel out of range");

endmodule

bind hop_channel_select_top hcs_checker #(
  .NUM_CHANNELS(NUM_CHANNELS)
) u_hcs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .channel   (res.payload.channel),
  .remapped  (res.payload.remapped),
  .map_error (res.payload.map_error)
);
